// ===== rtl/lte_pkg.sv =====
// Shared types, constants and the pixel quantizer for the 3x3 Laplacian edge block.
// No dependencies.
`default_nettype none

package lte_pkg;

	// quantized grey level, 0 to 2
	typedef logic [1:0] level_t;

	// one pair of line store entries at a column
	typedef struct packed {
		level_t upper;
		level_t middle;
	} line_pair_t;

	localparam logic [7:0] QUANT_STEP_1 = 8'd100;
	localparam logic [7:0] QUANT_STEP_2 = 8'd200;
	localparam logic [7:0] EDGE_ON      = 8'd255;
	localparam logic [7:0] EDGE_OFF     = 8'd0;
	localparam logic [10:0] WIDTH_RESET = 11'd640;
	localparam int unsigned WIDTH_MIN   = 3;

	// integer division of an 8-bit pixel by 100: two compares
	function automatic level_t quantize(input logic [7:0] px);
		level_t lv;
		if (px >= QUANT_STEP_2) begin
			lv = 2'd2;
		end else if (px >= QUANT_STEP_1) begin
			lv = 2'd1;
		end else begin
			lv = 2'd0;
		end
		return lv;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lte_line_buf.sv =====
// Two line stores of quantized levels, held as one memory of level pairs.
// Registered read with a bypass for a write to the same column at the read edge.
// Depends on lte_pkg.
`default_nettype none

module lte_line_buf #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   rd_en,
	input  wire  [AW-1:0]         rd_addr,
	input  wire                   wr_en,
	input  wire  [AW-1:0]         wr_addr,
	input  wire  lte_pkg::line_pair_t wr_data,
	output lte_pkg::line_pair_t   rd_data
);
	import lte_pkg::*;

	line_pair_t mem [DEPTH];
	line_pair_t rd_q;
	line_pair_t byp_q;
	logic       hit_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port; hold data while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			byp_q <= wr_data;
		end
	end

	// flag a write to the read column at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (rd_en) begin
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = hit_q ? byp_q : rd_q;

endmodule

`default_nettype wire

// ===== rtl/lte_kernel.sv =====
// 3x3 window of quantized levels, Laplacian sum, threshold and result register.
// Depends on lte_pkg.
`default_nettype none

module lte_kernel #(
	parameter int unsigned CW = 10,
	parameter int unsigned RW = 12
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              advance,
	input  wire              item_valid,
	input  wire  lte_pkg::level_t level,
	input  wire  lte_pkg::level_t up,
	input  wire  lte_pkg::level_t mid,
	input  wire  [CW-1:0]    col,
	input  wire  [RW-1:0]    row,
	output logic             res_valid,
	output logic [7:0]       edge_value,
	output logic [11:0]      out_row,
	output logic [9:0]       out_col
);
	import lte_pkg::*;

	level_t     win_q [3][3];
	level_t     win_n [3][3];
	logic [4:0] nb_sum;
	logic [4:0] centre_x8;
	logic       interior;
	logic       step_en;
	logic [CW+9:0] col_ext;
	logic [RW+11:0] row_ext;

	assign step_en = advance && item_valid;

	// shift window left, new column enters on the right
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_n[r][0] = win_q[r][1];
			win_n[r][1] = win_q[r][2];
		end
		win_n[0][2] = up;
		win_n[1][2] = mid;
		win_n[2][2] = level;
	end

	// sum of the eight neighbours against eight times the centre
	always_comb begin
		nb_sum = 5'd0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!(r == 1 && c == 1)) begin
					nb_sum = nb_sum + {3'd0, win_n[r][c]};
				end
			end
		end
		centre_x8 = {win_n[1][1], 3'd0};
	end

	assign interior = (row >= RW'(2)) && (col >= CW'(2));
	assign col_ext  = (CW+10)'(CW'(col - CW'(1)));
	assign row_ext  = (RW+12)'(RW'(row - RW'(1)));

	// advance window on every transfer through the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= 2'd0;
				end
			end
		end else if (step_en) begin
			win_q <= win_n;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= item_valid && interior;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			edge_value <= (centre_x8 > nb_sum) ? EDGE_ON : EDGE_OFF;
			out_row    <= row_ext[11:0];
			out_col    <= col_ext[9:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/laplacian_threshold_edge_3x3.sv =====
// Top level of the streaming 3x3 Laplacian edge detector with binary threshold.
// Depends on lte_pkg, lte_line_buf and lte_kernel.
//
// Usage:
//   Pixels enter on the pix channel (pix_valid / pix_stall) in raster order,
//   frame_start high on the first pixel of a frame. Results leave on the res
//   channel (res_valid / res_stall): edge_value 255 or 0 with the row and
//   column of the interior pixel. Border positions give no result.
//   Throughput is one pixel per cycle unless the pipeline holds; the line
//   store memory has one read and one write port, each used once per pixel.
//   The result of a transferred pixel is held in the input stage, then
//   registered in the result register once that is free or being taken.
//   When the receiver stalls with a result waiting, pix_stall rises and the
//   pipeline holds; nothing is dropped.
//   cfg_valid / cfg_ready write image_width (clamped to 3..MAX_WIDTH); cfg_ready
//   is always high. Write it only while the block is idle.
//   Reset clears counters, the window and image_width (to 640). The line
//   stores are not cleared; the first two rows of a frame fill them.
`default_nettype none

module laplacian_threshold_edge_3x3 #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_ROWS  = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [10:0] cfg_data,
	input  wire         pix_valid,
	output logic        pix_stall,
	input  wire  [7:0]  pixel,
	input  wire         frame_start,
	output logic        res_valid,
	input  wire         res_stall,
	output logic [7:0]  edge_value,
	output logic [11:0] out_row,
	output logic [9:0]  out_col
);
	import lte_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_ROWS);
	localparam int unsigned LW = ((CW > 11) ? CW : 11) + 1;

	logic [10:0]   width_q;
	logic [CW-1:0] column_count_q;
	logic [RW-1:0] row_count_q;
	logic [LW-1:0] width_ext;
	logic [LW-1:0] width_eff;
	logic [CW-1:0] col_cur;
	logic [RW-1:0] row_cur;
	logic          row_end;
	logic          advance;
	logic          accept;

	logic          valid_s1;
	level_t        level_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;

	line_pair_t    rd_pair;
	line_pair_t    wr_pair;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			width_q <= cfg_data;
		end
	end

	// clamp width to the supported range
	always_comb begin
		width_ext = LW'(width_q);
		if (width_ext < LW'(WIDTH_MIN)) begin
			width_eff = LW'(WIDTH_MIN);
		end else if (width_ext > LW'(MAX_WIDTH)) begin
			width_eff = LW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
	end

	// pipeline moves unless a result waits on a stalled receiver
	assign advance   = !(res_valid && res_stall);
	assign pix_stall = !advance;
	assign accept    = pix_valid && advance;

	// position of the incoming pixel
	assign col_cur = frame_start ? '0 : column_count_q;
	assign row_cur = frame_start ? '0 : row_count_q;
	assign row_end = (LW'(col_cur) + LW'(1)) >= width_eff;

	// raster counters, row count saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (accept) begin
			if (row_end) begin
				column_count_q <= '0;
				row_count_q    <= (row_cur < RW'(MAX_ROWS - 1)) ? RW'(row_cur + RW'(1))
				                                                : row_cur;
			end else begin
				column_count_q <= CW'(col_cur + CW'(1));
				row_count_q    <= row_cur;
			end
		end
	end

	// input stage: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	// input stage: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= quantize(pixel);
			col_s1   <= col_cur;
			row_s1   <= row_cur;
		end
	end

	// shift the column up one row in the line stores
	assign wr_pair.upper  = rd_pair.middle;
	assign wr_pair.middle = level_s1;

	lte_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.wr_en   (advance && valid_s1),
		.wr_addr (col_s1),
		.wr_data (wr_pair),
		.rd_data (rd_pair)
	);

	lte_kernel #(
		.CW (CW),
		.RW (RW)
	) u_kernel (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item_valid (valid_s1),
		.level      (level_s1),
		.up         (rd_pair.upper),
		.mid        (rd_pair.middle),
		.col        (col_s1),
		.row        (row_s1),
		.res_valid  (res_valid),
		.edge_value (edge_value),
		.out_row    (out_row),
		.out_col    (out_col)
	);

endmodule

`default_nettype wire

// ===== sim/laplacian_threshold_edge_3x3_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for laplacian_threshold_edge_3x3: random raster frames against a
// cycle-free line-store and window predictor. Depends on lte_pkg and the block's RTL.

module laplacian_threshold_edge_3x3_tb;
	import lte_pkg::*;

	localparam int unsigned MAX_W = 1024;
	localparam int unsigned MAX_R = 4096;
	localparam int unsigned RANDOM_PHASES = 4;
	localparam int unsigned PHASE_ITEMS = 120;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned MAX_REPORTS = 10;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [7:0] px;
		logic       fs;
	} pixel_item_t;

	typedef struct {
		logic [7:0]  edge_v;
		logic [11:0] row;
		logic [9:0]  col;
	} edge_result_t;

	// two hand-built frames at width 3: strong edge, strong anti-edge, sum of exactly one
	localparam logic [7:0] DIRECTED_PX [0:20] = '{
		8'd0,   8'd0,   8'd0,
		8'd0,   8'd255, 8'd0,
		8'd0,   8'd0,   8'd0,
		8'd255, 8'd255, 8'd255,
		8'd199, 8'd199, 8'd199,
		8'd99,  8'd100, 8'd199,
		8'd199, 8'd199, 8'd199
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;
	logic        pix_valid = 1'b0;
	logic        pix_stall;
	logic [7:0]  pixel = '0;
	logic        frame_start = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [7:0]  edge_value;
	logic [11:0] out_row;
	logic [9:0]  out_col;

	pixel_item_t  pending_pixels[$];
	edge_result_t expected_edges[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned cfg_acks = 0;
	int unsigned hold_left = 0;
	logic        hold_arm = 1'b0;
	logic        hold_done = 1'b0;

	// predictor state
	level_t      upper_levels [MAX_W];
	level_t      middle_levels [MAX_W];
	level_t      win [9];
	logic [9:0]  col_count = '0;
	logic [11:0] row_count = '0;
	logic [10:0] model_width = WIDTH_RESET;

	laplacian_threshold_edge_3x3 #(
		.MAX_WIDTH(MAX_W),
		.MAX_ROWS(MAX_R)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel(pixel),
		.frame_start(frame_start),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.edge_value(edge_value),
		.out_row(out_row),
		.out_col(out_col)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// advance the window and line stores by one pixel, queue the edge it completes
	task automatic predict_edge(input logic [7:0] px, input logic fs);
		int unsigned eff_w;
		int unsigned c;
		level_t lv;
		level_t up;
		level_t mid;
		int sum;
		edge_result_t r;
		lv = level_t'(px / 8'd100);
		eff_w = model_width;
		if (eff_w < WIDTH_MIN) eff_w = WIDTH_MIN;
		if (eff_w > MAX_W) eff_w = MAX_W;
		if (fs) begin
			col_count = '0;
			row_count = '0;
		end
		c = col_count;
		up = upper_levels[c];
		mid = middle_levels[c];
		for (int k = 0; k < 3; k++) begin
			win[k * 3] = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = up;
		win[5] = mid;
		win[8] = lv;
		upper_levels[c] = mid;
		middle_levels[c] = lv;
		if (row_count >= 12'd2 && c >= 2) begin
			sum = 8 * int'(win[4]);
			for (int k = 0; k < 9; k++) begin
				if (k != 4) sum -= int'(win[k]);
			end
			r.edge_v = (sum >= 1) ? EDGE_ON : EDGE_OFF;
			r.row = row_count - 12'd1;
			r.col = 10'(c - 1);
			expected_edges.push_back(r);
		end
		if (c + 1 >= eff_w) begin
			col_count = '0;
			if (row_count < 12'(MAX_R - 1)) row_count = row_count + 12'd1;
		end else begin
			col_count = 10'(c + 1);
		end
	endtask

	// driver: register writes reach the predictor, pixel transfers feed it
	always @(posedge clk) begin
		pixel_item_t item;
		if (cfg_valid && cfg_ready) begin
			model_width = cfg_data;
			cfg_acks <= cfg_acks + 1;
		end
		if (pix_valid && !pix_stall) begin
			predict_edge(pixel, frame_start);
		end
		if (arst_n && (!pix_valid || !pix_stall)) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item = pending_pixels.pop_front();
				pix_valid <= 1'b1;
				pixel <= item.px;
				frame_start <= item.fs;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, started once on request
	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
	endtask

	// monitor: check each result transfer against the oldest expected edge
	always @(posedge clk) begin
		edge_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_edges.size() == 0) begin
				flag_error($sformatf("unexpected result: edge %0d row %0d col %0d",
					edge_value, out_row, out_col));
			end else begin
				want = expected_edges.pop_front();
				if (edge_value !== want.edge_v || out_row !== want.row
						|| out_col !== want.col) begin
					flag_error($sformatf(
						"mismatch: expected edge %0d row %0d col %0d, got edge %0d row %0d col %0d",
						want.edge_v, want.row, want.col, edge_value, out_row, out_col));
				end
			end
		end
		res_stall <= arst_n && ((hold_left != 0) || ($urandom_range(99) < recv_stall_pct));
	end

	task automatic queue_pixel(input logic [7:0] px, input logic fs);
		pixel_item_t item;
		item.px = px;
		item.fs = fs;
		pending_pixels.push_back(item);
	endtask

	// favor the quantizer thresholds, otherwise uniform
	function automatic logic [7:0] pick_pixel();
		logic [7:0] px;
		case ($urandom_range(7))
			0: px = 8'd0;
			1: px = 8'd99;
			2: px = 8'd100;
			3: px = 8'd199;
			4: px = 8'd200;
			5: px = 8'd255;
			default: px = 8'($urandom_range(255));
		endcase
		return px;
	endfunction

	task automatic queue_raster(input int unsigned count, input logic first_fs);
		for (int unsigned i = 0; i < count; i++) begin
			queue_pixel(pick_pixel(), (i == 0) ? first_fs : 1'b0);
		end
	endtask

	// one frame: mostly three or more full rows, sometimes short or cut mid-row,
	// with a rare stray frame start as noise
	task automatic queue_frame(input int unsigned w, output int unsigned n);
		int unsigned rows;
		int unsigned last_len;
		int unsigned len;
		rows = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
		last_len = ($urandom_range(3) == 0) ? $urandom_range(1, w) : w;
		n = 0;
		for (int unsigned r = 0; r < rows; r++) begin
			len = (r == rows - 1) ? last_len : w;
			for (int unsigned c = 0; c < len; c++) begin
				queue_pixel(pick_pixel(), (n == 0) || ($urandom_range(99) < 2));
				n++;
			end
		end
	endtask

	task automatic set_idle(input idle_mode_t mode);
		@(negedge clk);
		send_idle_pct = (mode == IDLE_SEND) ? 79 : (mode == IDLE_BOTH) ? 20 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 79 : (mode == IDLE_BOTH) ? 20 : 0;
	endtask

	task automatic write_width(input logic [10:0] w);
		int unsigned seen;
		@(posedge clk);
		seen = cfg_acks;
		cfg_valid <= 1'b1;
		cfg_data <= w;
		wait (cfg_acks != seen);
		cfg_valid <= 1'b0;
	endtask

	// wait until every pixel is taken and every edge has arrived, then let the pipe settle
	task automatic drain();
		while (pending_pixels.size() != 0 || pix_valid || expected_edges.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned phase_items;
		int unsigned phase_no;
		int unsigned n;
		int unsigned w_cfg;
		int unsigned eff;
		for (int i = 0; i < MAX_W; i++) begin
			upper_levels[i] = '0;
			middle_levels[i] = '0;
		end
		for (int i = 0; i < 9; i++) win[i] = '0;

		// hold reset
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset width, stop in the middle of the third row
		set_idle(IDLE_NONE);
		queue_raster(2 * 640 + 20, 1'b1);
		drain();

		// shrink the width mid-row: the row ends after the next pixel
		write_width(11'd10);
		set_idle(IDLE_SEND);
		queue_raster(1 + 3 * 10, 1'b0);
		drain();

		// width below range acts as 3; hand-built frames
		write_width(11'd0);
		set_idle(IDLE_RECV);
		foreach (DIRECTED_PX[i]) begin
			queue_pixel(DIRECTED_PX[i], (i == 0) || (i == 12));
		end
		drain();

		// random frames, new width and idling per phase
		for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
			case ($urandom_range(9))
				0: w_cfg = $urandom_range(2);
				1, 2: w_cfg = $urandom_range(11, 40);
				default: w_cfg = $urandom_range(3, 10);
			endcase
			eff = (w_cfg < WIDTH_MIN) ? WIDTH_MIN : w_cfg;
			write_width(11'(w_cfg));
			set_idle(idle_mode_t'(phase_no % 4));
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				queue_frame(eff, n);
				phase_items += n;
			end
			// long hold-off while the sender keeps offering fills the pipe
			if (phase_no == 0) hold_arm = 1'b1;
			drain();
		end

		if (mismatch_count == 0 && expected_edges.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
